[hw/rtl/kwm_pkg.sv]
// Shared types and constants for the k-way sorted merge block.
// Used by kwm_ctrl, kwm_datapath and k_way_sorted_merge_top; no dependencies.
`default_nettype none

package kwm_pkg;

    localparam int NUM_LISTS  = 8;
    localparam int LIST_DEPTH = 256;
    localparam int VALUE_BITS = 32;

    localparam int LIST_BITS = $clog2(NUM_LISTS);
    localparam int SLOT_BITS = $clog2(LIST_DEPTH);
    // one extra bit tells a full list from an empty one
    localparam int PTR_BITS  = SLOT_BITS + 1;
    localparam int ADDR_BITS = LIST_BITS + SLOT_BITS;
    localparam int MEM_WORDS = NUM_LISTS * LIST_DEPTH;

    localparam int CMD_BITS    = 2;
    localparam int SEL_BITS    = 3;
    localparam int DATA_BITS   = 32;
    localparam int STATUS_BITS = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RSVD  = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_REFILL
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic refill;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic pop_found;
    } dp_stat_t;

    // one node of the minimum search tree
    typedef struct packed {
        logic                         vld;
        logic signed [VALUE_BITS-1:0] val;
        logic [LIST_BITS-1:0]         idx;
    } node_t;

endpackage

`default_nettype wire

[hw/rtl/kwm_ctrl.sv]
// Command sequencer for the k-way sorted merge block.
// Depends on kwm_pkg (state and command types, control structs).
`default_nettype none

module kwm_ctrl
    import kwm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [CMD_BITS-1:0] cmd,
    input  wire dp_stat_t            dp_stat,
    output ctl_t                     ctl,
    output logic                     busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // a successful pop leaves one list with a stale head
                if (start && (cmd_t'(cmd) == CMD_POP) && dp_stat.pop_found)
                begin
                    state_next = ST_REFILL;
                end
            end
            ST_REFILL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl  = '0;
        busy = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.accept = start;
            end
            ST_REFILL:
            begin
                ctl.refill = 1'b1;
                busy       = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/kwm_datapath.sv]
// Datapath of the k-way sorted merge block: list pointers, head registers,
// element memory, minimum search tree and result registers. Uses kwm_pkg.
`default_nettype none

module kwm_datapath
    import kwm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ctl_t                   ctl,
    output dp_stat_t                    dp_stat,
    input  wire logic [CMD_BITS-1:0]    cmd,
    input  wire logic [SEL_BITS-1:0]    list_sel,
    input  wire logic [DATA_BITS-1:0]   data_in,
    output logic                        done,
    output logic [DATA_BITS-1:0]        data_out,
    output logic [SEL_BITS-1:0]         source_list,
    output logic [STATUS_BITS-1:0]      status
);

    logic [PTR_BITS-1:0]   wp_reg [NUM_LISTS];
    logic [PTR_BITS-1:0]   rp_reg [NUM_LISTS];
    logic [VALUE_BITS-1:0] head_reg [NUM_LISTS];
    logic [VALUE_BITS-1:0] mem [MEM_WORDS];
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic [LIST_BITS-1:0]  refill_idx_reg;

    logic                   done_reg;
    logic [DATA_BITS-1:0]   data_out_reg;
    logic [SEL_BITS-1:0]    source_list_reg;
    logic [STATUS_BITS-1:0] status_reg;

    cmd_t                  cmd_e;
    logic                  sel_ok;
    logic [LIST_BITS-1:0]  sel_idx;
    logic [PTR_BITS-1:0]   sel_fill;
    logic                  sel_full;
    logic                  sel_empty;
    logic [VALUE_BITS-1:0] value;
    logic                  do_push;
    logic                  do_pop;
    logic                  do_clear;
    node_t                 best;
    logic [PTR_BITS-1:0]   best_rp_next;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [ADDR_BITS-1:0]  wr_addr;

    assign cmd_e     = cmd_t'(cmd);
    assign sel_ok    = (int'(list_sel) < NUM_LISTS);
    assign sel_idx   = LIST_BITS'(list_sel);
    assign sel_fill  = wp_reg[sel_idx] - rp_reg[sel_idx];
    assign sel_full  = (sel_fill >= PTR_BITS'(LIST_DEPTH));
    assign sel_empty = (sel_fill == '0);
    assign value     = VALUE_BITS'(data_in);

    assign do_push  = ctl.accept && (cmd_e == CMD_PUSH) && sel_ok && !sel_full;
    assign do_pop   = ctl.accept && (cmd_e == CMD_POP) && best.vld;
    assign do_clear = ctl.accept && (cmd_e == CMD_CLEAR);

    // minimum over non-empty heads: heap-ordered tree, leaves at NUM_LISTS..
    // lower index sits on the left, so ties keep the lower list
    always_comb
    begin
        node_t tree [2*NUM_LISTS];
        for (int i = 0; i < 2*NUM_LISTS; i++)
        begin
            tree[i] = '0;
        end
        for (int i = 0; i < NUM_LISTS; i++)
        begin
            tree[NUM_LISTS + i].vld = (wp_reg[i] != rp_reg[i]);
            tree[NUM_LISTS + i].val = $signed(head_reg[i]);
            tree[NUM_LISTS + i].idx = LIST_BITS'(i);
        end
        for (int i = NUM_LISTS - 1; i >= 1; i--)
        begin
            if (tree[2*i].vld && (!tree[2*i+1].vld || (tree[2*i].val <= tree[2*i+1].val)))
            begin
                tree[i] = tree[2*i];
            end
            else
            begin
                tree[i] = tree[2*i+1];
            end
        end
        best = tree[1];
    end

    assign dp_stat.pop_found = best.vld;
    assign best_rp_next      = rp_reg[best.idx] + PTR_BITS'(1);
    assign rd_addr           = {best.idx, best_rp_next[SLOT_BITS-1:0]};
    assign wr_addr           = {sel_idx, wp_reg[sel_idx][SLOT_BITS-1:0]};

    // element memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_addr] <= value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                wp_reg[i] <= '0;
                rp_reg[i] <= '0;
            end
        end
        else if (do_clear)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                wp_reg[i] <= '0;
                rp_reg[i] <= '0;
            end
        end
        else
        begin
            if (do_push)
            begin
                wp_reg[sel_idx] <= wp_reg[sel_idx] + PTR_BITS'(1);
            end
            if (do_pop)
            begin
                rp_reg[best.idx] <= best_rp_next;
            end
        end
    end

    // head of a non-empty list mirrors the word at its read pointer, except while its refill is pending
    always_ff @(posedge clk)
    begin
        if (do_push && sel_empty)
        begin
            head_reg[sel_idx] <= value;
        end
        else if (ctl.refill)
        begin
            head_reg[refill_idx_reg] <= rd_data_reg;
        end
        if (do_pop)
        begin
            refill_idx_reg <= best.idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            data_out_reg    <= '0;
            source_list_reg <= '0;
            status_reg      <= STAT_OK;
            case (cmd_e)
                CMD_PUSH:
                begin
                    if (!sel_ok || sel_full)
                    begin
                        status_reg <= STAT_FULL;
                    end
                end
                CMD_POP:
                begin
                    if (best.vld)
                    begin
                        data_out_reg    <= DATA_BITS'(best.val);
                        source_list_reg <= SEL_BITS'(best.idx);
                    end
                    else
                    begin
                        status_reg <= STAT_EMPTY;
                    end
                end
                default:
                begin
                    status_reg <= STAT_OK;
                end
            endcase
        end
    end

    assign done        = done_reg;
    assign data_out    = data_out_reg;
    assign source_list = source_list_reg;
    assign status      = status_reg;

endmodule

`default_nettype wire

[hw/rtl/k_way_sorted_merge_top.sv]
// Top level of the k-way sorted merge block.
// Instantiates kwm_ctrl and kwm_datapath; uses kwm_pkg.
`default_nettype none

// K-way merge over bounded per-list FIFOs.
// Command channel: a word (cmd, list_sel, data_in) is taken at a rising edge
// with start high and busy low. cmd: push data_in to list list_sel, pop the
// smallest head over all non-empty lists (ties to the lowest list), clear
// all lists, or no-op.
// Result channel: every command yields one word on data_out, source_list and
// status, marked by done for exactly one cycle, in the cycle after the command
// was taken. The receiver has no way to stall; each result must be caught.
// Status: ok, pop with every list empty, or push refused (list full).
// Back-to-back: after a push, clear or empty pop the block stays idle and takes
// the next command; a pop that returns a value is followed by a refill state with
// busy high, in which the winning list's new head is loaded from the element memory (registered read port).
// Minimum search is a tree over per-list head registers in the accept cycle.
// Reset: all lists empty, no result pending, busy low. Element memory is not
// cleared; only words that were pushed are ever returned.
module k_way_sorted_merge_top
    import kwm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [CMD_BITS-1:0]    cmd,
    input  wire logic [SEL_BITS-1:0]    list_sel,
    input  wire logic [DATA_BITS-1:0]   data_in,
    output logic                        done,
    output logic [DATA_BITS-1:0]        data_out,
    output logic [SEL_BITS-1:0]         source_list,
    output logic [STATUS_BITS-1:0]      status
);

    ctl_t     ctl;
    dp_stat_t dp_stat;

    kwm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .dp_stat (dp_stat),
        .ctl     (ctl),
        .busy    (busy)
    );

    kwm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .dp_stat     (dp_stat),
        .cmd         (cmd),
        .list_sel    (list_sel),
        .data_in     (data_in),
        .done        (done),
        .data_out    (data_out),
        .source_list (source_list),
        .status      (status)
    );

endmodule

`default_nettype wire
